>>> sv/slcfp_pkg.sv
// Shared types, constants and the CRC-8 step for the sync/length/CRC-8 frame parser.
// No dependencies; imported by slcfp_parser, slcfp_out_stage and the top level.
package slcfp_pkg;

  localparam logic [7:0] SYNC_A      = 8'h51;
  localparam logic [7:0] SYNC_B      = 8'hAC;
  localparam logic [7:0] TYPE_READY  = 8'h40;
  localparam logic [7:0] TYPE_METRIC = 8'h55;
  localparam logic [7:0] CRC_INIT    = 8'h01;
  localparam logic [7:0] CRC_POLY    = 8'h8C;  // reflected Dallas/Maxim polynomial

  localparam int unsigned LEN_W    = 15;
  localparam int unsigned METRIC_W = 32;

  typedef enum logic [1:0] {
    EV_READY = 2'd0,
    EV_GOOD  = 2'd1,
    EV_BAD   = 2'd2
  } event_e;

  typedef struct packed {
    event_e              event_res;
    logic [7:0]          frame_type;
    logic [LEN_W-1:0]    frame_length;
    logic                metric_valid;
    logic [METRIC_W-1:0] metric_value;
  } result_t;

  // One byte through the reflected CRC-8, bit at a time.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> sv/slcfp_parser.sv
// Frame parser state machine: sync hunt, length decode, CRC-8 and metric capture.
// Depends on slcfp_pkg.
module slcfp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              enable_i,
  input  logic              byte_valid_i,
  input  logic [7:0]        byte_i,
  input  logic              result_ready_i,
  output logic              byte_take_o,
  output logic              res_valid_o,
  output slcfp_pkg::result_t res_o
);
  import slcfp_pkg::*;

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_LEN1  = 3'd2;
  localparam logic [2:0] PH_LEN2  = 3'd3;
  localparam logic [2:0] PH_TYPE  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_CHECK = 3'd6;

  logic [2:0]          phase_q, phase_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [LEN_W-1:0]    count_q, count_d;
  logic [7:0]          crc_q, crc_d;
  logic [7:0]          type_q, type_d;
  logic [METRIC_W-1:0] metric_q, metric_d;

  logic                emit;
  logic                good;
  logic                met;
  logic [LEN_W-1:0]    count_inc;
  logic [1:0]          lane;
  logic                advance;

  assign count_inc = count_q + LEN_W'(1);
  assign lane      = count_q[1:0] - 2'd2;  // data byte 2..5 -> lane 0..3

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    count_d  = count_q;
    crc_d    = crc_q;
    type_d   = type_q;
    metric_d = metric_q;
    emit     = 1'b0;
    good     = (byte_i == crc_q);
    met      = good && (type_q == TYPE_METRIC);
    res_o.event_res    = EV_READY;
    res_o.frame_type   = type_q;
    res_o.frame_length = len_q;
    res_o.metric_valid = 1'b0;
    res_o.metric_value = '0;
    unique case (phase_q)
      PH_SYNC2: begin
        phase_d = (byte_i == SYNC_B) ? PH_LEN1 : PH_SYNC1;
      end
      PH_LEN1: begin
        len_d   = LEN_W'(byte_i);
        phase_d = byte_i[7] ? PH_LEN2 : PH_TYPE;
      end
      PH_LEN2: begin
        len_d   = {byte_i, len_q[6:0]};
        phase_d = PH_TYPE;
      end
      PH_TYPE: begin
        type_d   = byte_i;
        metric_d = '0;
        if (byte_i == TYPE_READY) begin
          emit             = 1'b1;
          res_o.frame_type = byte_i;
          phase_d          = PH_SYNC1;
          count_d          = '0;
          crc_d            = CRC_INIT;
        end else begin
          crc_d   = crc8_step(CRC_INIT, byte_i);
          count_d = LEN_W'(1);
          phase_d = (len_q <= LEN_W'(2)) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        if (count_q >= LEN_W'(2) && count_q <= LEN_W'(5)) begin
          metric_d = metric_q | (METRIC_W'(byte_i) << {lane, 3'b000});
        end
        crc_d   = crc8_step(crc_q, byte_i);
        count_d = count_inc;
        // length >= 3 here, so the subtraction cannot wrap
        if (count_inc > (len_q - LEN_W'(2))) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        emit               = 1'b1;
        res_o.event_res    = good ? EV_GOOD : EV_BAD;
        res_o.metric_valid = met;
        res_o.metric_value = met ? metric_q : '0;
        phase_d            = PH_SYNC1;
        count_d            = '0;
        crc_d              = CRC_INIT;
      end
      default: begin
        phase_d = (byte_i == SYNC_A) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  // A byte that ends a frame waits for room in the result register.
  assign res_valid_o = byte_valid_i && enable_i && emit;
  assign byte_take_o = byte_valid_i && (!(enable_i && emit) || result_ready_i);
  assign advance     = byte_take_o && enable_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SYNC1;
      len_q    <= '0;
      count_q  <= '0;
      crc_q    <= CRC_INIT;
      type_q   <= '0;
      metric_q <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      count_q  <= count_d;
      crc_q    <= crc_d;
      type_q   <= type_d;
      metric_q <= metric_d;
    end
  end

  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SYNC1) |-> (crc_q == CRC_INIT && count_q == '0))
    else $error("hunt phase with stale CRC or count");

  a_emit_returns_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && byte_take_o) |=> (phase_q == PH_SYNC1))
    else $error("parser did not return to hunt after a frame ended");

  a_metric_only_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.metric_valid) |->
      (res_o.event_res == EV_GOOD && res_o.frame_type == TYPE_METRIC))
    else $error("metric flagged on a frame that is not a good metric frame");

  a_no_result_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> enable_i)
    else $error("result raised while parser disabled");

endmodule

>>> sv/slcfp_out_stage.sv
// Result register between the parser and the output channel.
// Depends on slcfp_pkg.
module slcfp_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  slcfp_pkg::result_t res_i,
  output logic               slot_free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output slcfp_pkg::result_t res_o
);
  import slcfp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign slot_free_o = !valid_q || out_ready_i;
  assign load        = res_valid_i && slot_free_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |-> !load)
    else $error("pending result overwritten");

  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (res_q.event_res == EV_READY || res_q.event_res == EV_GOOD ||
                 res_q.event_res == EV_BAD))
    else $error("undefined event code on output");

endmodule

>>> sv/sync_length_crc8_frame_parser_core.sv
// Sync/length/CRC-8 frame parser: one received byte per input transaction; at most one
// result transaction per byte, raised when a frame ends (ready message, good or bad
// checksum). Each byte passes an input register, then the parser state machine with a
// single CRC-8 byte step, then a result register, so a byte can be taken every cycle; a
// byte that ends a frame waits in the input register only while the result register
// still holds an untaken result. Bytes are ignored while enable is 0. Depends on
// slcfp_pkg, slcfp_parser and slcfp_out_stage.
module sync_length_crc8_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [7:0]  frame_type_o,
  output logic [14:0] frame_length_o,
  output logic        metric_valid_o,
  output logic [31:0] metric_value_o
);
  import slcfp_pkg::*;

  logic       enable_q;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_accept;
  logic       byte_take;
  logic       res_valid;
  logic       slot_free;
  result_t    res_parse;
  result_t    res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !in_valid_q || byte_take;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (byte_take) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  slcfp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .enable_i      (enable_q),
    .byte_valid_i  (in_valid_q),
    .byte_i        (in_byte_q),
    .result_ready_i(slot_free),
    .byte_take_o   (byte_take),
    .res_valid_o   (res_valid),
    .res_o         (res_parse)
  );

  slcfp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res_parse),
    .slot_free_o(slot_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign event_res_o    = res_out.event_res;
  assign frame_type_o   = res_out.frame_type;
  assign frame_length_o = res_out.frame_length;
  assign metric_valid_o = res_out.metric_valid;
  assign metric_value_o = res_out.metric_value;

  a_take_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_take |-> in_valid_q)
    else $error("parser consumed an empty input register");

  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (in_valid_q && enable_q))
    else $error("result raised without a pending enabled byte");

  a_held_byte_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !byte_take) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("pending byte lost or changed");

endmodule

>>> tb/frame_result_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sync/length/CRC-8 frame parser: follows every accepted byte and
// enable write, predicts the frame-end results and compares them with the result channel.
// Depends on slcfp_pkg for result_t, event_e and the protocol constants.
module frame_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  event_res_i,
  input  logic [7:0]  frame_type_i,
  input  logic [14:0] frame_length_i,
  input  logic        metric_valid_i,
  input  logic [31:0] metric_value_i,
  output int          errors_o,
  output int          pending_o
);
  import slcfp_pkg::*;

  typedef enum logic [2:0] {
    SEEK_SYNC_A,
    SEEK_SYNC_B,
    LEN_FIRST,
    LEN_SECOND,
    TYPE_FIELD,
    DATA_FIELD,
    CHECKSUM_FIELD
  } parse_phase_e;

  parse_phase_e  phase_q;
  logic          enable_q;
  logic [14:0]   len_q;
  logic [14:0]   count_q;
  logic [7:0]    crc_q;
  logic [7:0]    type_q;
  logic [31:0]   metric_q;
  result_t       frame_ends_due[$];
  int            mismatch_n;

  // Reflected CRC-8, folding in one data bit per step (LSB first).
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    int         i;
    r = crc;
    for (i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  task automatic back_to_hunt();
    phase_q = SEEK_SYNC_A;
    count_q = '0;
    crc_q   = CRC_INIT;
  endtask

  task automatic advance_parser(input logic [7:0] b);
    result_t r;
    logic    good;
    logic    met;
    if (!enable_q) return;
    case (phase_q)
      SEEK_SYNC_B: begin
        phase_q = (b == SYNC_B) ? LEN_FIRST : SEEK_SYNC_A;
      end
      LEN_FIRST: begin
        len_q   = {7'd0, b};
        phase_q = b[7] ? LEN_SECOND : TYPE_FIELD;
      end
      LEN_SECOND: begin
        len_q   = {b, len_q[6:0]};
        phase_q = TYPE_FIELD;
      end
      TYPE_FIELD: begin
        type_q   = b;
        metric_q = '0;
        if (b == TYPE_READY) begin
          r.event_res    = EV_READY;
          r.frame_type   = b;
          r.frame_length = len_q;
          r.metric_valid = 1'b0;
          r.metric_value = '0;
          frame_ends_due.push_back(r);
          back_to_hunt();
        end else begin
          crc_q   = crc_update(CRC_INIT, b);
          count_q = 15'd1;
          phase_q = (len_q <= 15'd2) ? CHECKSUM_FIELD : DATA_FIELD;
        end
      end
      DATA_FIELD: begin
        // the second to fifth data bytes form the little-endian metric
        if (count_q >= 15'd2 && count_q <= 15'd5)
          metric_q = metric_q | (32'(b) << (8 * (int'(count_q) - 2)));
        crc_q   = crc_update(crc_q, b);
        count_q = count_q + 15'd1;
        if (int'(count_q) > int'(len_q) - 2) phase_q = CHECKSUM_FIELD;
      end
      CHECKSUM_FIELD: begin
        good           = (b == crc_q);
        met            = good && (type_q == TYPE_METRIC);
        r.event_res    = good ? EV_GOOD : EV_BAD;
        r.frame_type   = type_q;
        r.frame_length = len_q;
        r.metric_valid = met;
        r.metric_value = met ? metric_q : 32'd0;
        frame_ends_due.push_back(r);
        back_to_hunt();
      end
      default: begin
        phase_q = (b == SYNC_A) ? SEEK_SYNC_B : SEEK_SYNC_A;
      end
    endcase
  endtask

  task automatic check_result();
    result_t e;
    if (frame_ends_due.size() == 0) begin
      mismatch_n++;
      $display("%0t: unexpected result: event %0d type %02h length %0d", $time,
               event_res_i, frame_type_i, frame_length_i);
      return;
    end
    e = frame_ends_due.pop_front();
    if (event_res_i !== e.event_res) begin
      mismatch_n++;
      $display("%0t: event_res expected %0d, got %0d", $time, e.event_res, event_res_i);
    end
    if (frame_type_i !== e.frame_type) begin
      mismatch_n++;
      $display("%0t: frame_type expected %02h, got %02h", $time, e.frame_type, frame_type_i);
    end
    if (frame_length_i !== e.frame_length) begin
      mismatch_n++;
      $display("%0t: frame_length expected %0d, got %0d", $time, e.frame_length,
               frame_length_i);
    end
    if (metric_valid_i !== e.metric_valid) begin
      mismatch_n++;
      $display("%0t: metric_valid expected %0b, got %0b", $time, e.metric_valid,
               metric_valid_i);
    end
    if (metric_value_i !== e.metric_value) begin
      mismatch_n++;
      $display("%0t: metric_value expected %08h, got %08h", $time, e.metric_value,
               metric_value_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   = 1'b1;
      len_q      = '0;
      type_q     = '0;
      metric_q   = '0;
      mismatch_n = 0;
      frame_ends_due.delete();
      back_to_hunt();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) advance_parser(rx_byte_i);
      if (cfg_we_i) enable_q = cfg_wdata_i;
      errors_o  <= mismatch_n;
      pending_o <= frame_ends_due.size();
    end
  end

endmodule

>>> tb/tb_sync_length_crc8_frame_parser_core.sv
`timescale 1ns / 1ps
// Testbench top for the frame parser: clock, reset, byte stream and enable writes,
// result back-pressure and the verdict. Depends on slcfp_pkg, the core and
// frame_result_checker.
module tb_sync_length_crc8_frame_parser_core;
  import slcfp_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  event_res_o;
  logic [7:0]  frame_type_o;
  logic [14:0] frame_length_o;
  logic        metric_valid_o;
  logic [31:0] metric_value_o;

  int          errors_n;
  int          pending_n;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          rx_hold_req;
  logic [7:0]  tx_bytes[$];

  sync_length_crc8_frame_parser_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .frame_type_o   (frame_type_o),
    .frame_length_o (frame_length_o),
    .metric_valid_o (metric_valid_o),
    .metric_value_o (metric_value_o)
  );

  frame_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_i    (event_res_o),
    .frame_type_i   (frame_type_o),
    .frame_length_i (frame_length_o),
    .metric_valid_i (metric_valid_o),
    .metric_value_i (metric_value_o),
    .errors_o       (errors_n),
    .pending_o      (pending_n)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Sync pair, length (one or two bytes) and type; unless ready, then data and CRC over type and data.
  function automatic void append_frame(input logic [7:0] kind, input logic [14:0] len,
                                       input bit ext, input bit bad_crc);
    logic [7:0] crc;
    logic [7:0] d;
    int         n;
    tx_bytes.push_back(SYNC_A);
    tx_bytes.push_back(SYNC_B);
    if (ext) begin
      tx_bytes.push_back({1'b1, len[6:0]});
      tx_bytes.push_back(len[14:7]);
    end else begin
      tx_bytes.push_back({1'b0, len[6:0]});
    end
    tx_bytes.push_back(kind);
    if (kind == TYPE_READY) return;
    crc = crc8_step(CRC_INIT, kind);
    n = (len > 15'd2) ? int'(len) - 2 : 0;
    repeat (n) begin
      d = 8'($urandom);
      tx_bytes.push_back(d);
      crc = crc8_step(crc, d);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    tx_bytes.push_back(crc);
  endfunction

  // Mostly well-formed frames with random content; some noise, broken sync
  // pairs and truncated frames.
  function automatic void build_random(input int target);
    int         pick;
    int         len;
    bit         ext;
    logic [7:0] d;
    while (tx_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 4))
          tx_bytes.push_back($urandom_range(0, 1) ? SYNC_A : 8'($urandom));
      end else if (pick < 18) begin
        d = $urandom_range(0, 1) ? SYNC_A : 8'($urandom);
        if (d == SYNC_B) d = 8'h00;
        tx_bytes.push_back(SYNC_A);
        tx_bytes.push_back(d);
      end else if (pick < 32) begin
        ext = 1'($urandom_range(0, 1));
        len = ext ? $urandom_range(0, 32767) : $urandom_range(0, 127);
        append_frame(TYPE_READY, 15'(len), ext, 1'b0);
      end else if (pick < 55) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 12);
        append_frame(TYPE_METRIC, 15'(len), $urandom_range(0, 7) == 0,
                     $urandom_range(0, 4) == 0);
      end else if (pick < 92) begin
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(128, 200)
                                           : $urandom_range(0, 14);
        ext = (len > 127) || ($urandom_range(0, 7) == 0);
        append_frame(8'($urandom), 15'(len), ext, $urandom_range(0, 4) == 0);
      end else begin
        append_frame(8'($urandom), 15'($urandom_range(3, 10)), 1'b0, 1'b0);
        repeat ($urandom_range(1, 3)) void'(tx_bytes.pop_back());
      end
    end
  endfunction

  // Called at a falling edge; returns at a falling edge with valid low.
  task automatic send_bytes(input int count);
    int gap;
    for (int k = 0; k < count && tx_bytes.size() > 0; k++) begin
      gap = pick_gap(tx_idle_pct);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      rx_byte_i  <= tx_bytes.pop_front();
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait for all results, then let bytes that end no frame clear the pipeline.
  task automatic settle();
    wait (pending_n == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_enable(input logic value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        gap = pick_gap(rx_idle_pct);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  initial begin
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    rst_ni      = 1'b0;
    rx_hold_req = 1'b0;
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: repeated first sync byte, longest ready frame, full and short metric
    // frames, length 1 with a bad checksum and the minimal length 0
    tx_bytes.push_back(SYNC_A);
    tx_bytes.push_back(SYNC_A);
    tx_bytes.push_back(SYNC_B);
    append_frame(TYPE_READY, 15'h7FFF, 1'b1, 1'b0);
    append_frame(TYPE_METRIC, 15'd7, 1'b0, 1'b0);
    append_frame(TYPE_METRIC, 15'd4, 1'b0, 1'b0);
    append_frame(8'h3C, 15'd1, 1'b0, 1'b1);
    append_frame(8'h00, 15'd0, 1'b0, 1'b0);
    send_bytes(tx_bytes.size());
    settle();
    write_enable(1'b1);

    build_random(150);
    send_bytes(tx_bytes.size());

    // disable in the middle of a metric frame; the parser must resume where it left off
    append_frame(TYPE_METRIC, 15'd8, 1'b0, 1'b0);
    send_bytes(6);
    settle();
    write_enable(1'b0);
    repeat (20) begin
      case ($urandom_range(0, 3))
        0:       tx_bytes.push_front(SYNC_A);
        1:       tx_bytes.push_front(SYNC_B);
        2:       tx_bytes.push_front(TYPE_READY);
        default: tx_bytes.push_front(8'($urandom));
      endcase
    end
    send_bytes(20);
    settle();
    write_enable(1'b1);
    send_bytes(tx_bytes.size());

    // back-to-back ready frames against a stalled result side
    rx_hold_req = 1'b1;
    tx_idle_pct = 0;
    repeat (10) append_frame(TYPE_READY, 15'($urandom_range(0, 127)), 1'b0, 1'b0);
    send_bytes(tx_bytes.size());

    rx_idle_pct = 0;
    build_random(100);
    send_bytes(tx_bytes.size());

    tx_idle_pct = 60;
    rx_idle_pct = 60;
    build_random(130);
    send_bytes(tx_bytes.size());

    wait (pending_n == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors_n == 0 && pending_n == 0) begin
      $display("sync_length_crc8_frame_parser_core verification clean");
    end else begin
      $display("sync_length_crc8_frame_parser_core verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sync_length_crc8_frame_parser_core verification failed");
    $finish;
  end

endmodule

>>> sim.f
sv/slcfp_pkg.sv
sv/slcfp_parser.sv
sv/slcfp_out_stage.sv
sv/sync_length_crc8_frame_parser_core.sv
tb/frame_result_checker.sv
tb/tb_sync_length_crc8_frame_parser_core.sv
